### rtl/ole_pkg.sv
`default_nettype none
package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W  = 32;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;
   localparam int FPOS_W = 5;
   localparam int ECNT_W = 5;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_USED_W = KEY_W + POS_W;
   localparam int REQ_DATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int REQ_USER_W = CMD_W;

   localparam int RSP_STAT_LO = 0;
   localparam int RSP_FPOS_LO = RSP_STAT_LO + STAT_W;
   localparam int RSP_MIN_LO  = RSP_FPOS_LO + FPOS_W;
   localparam int RSP_MAX_LO  = RSP_MIN_LO + KEY_W;
   localparam int RSP_ECNT_LO = RSP_MAX_LO + KEY_W;
   localparam int RSP_USED_W  = RSP_ECNT_LO + ECNT_W;
   localparam int RSP_DATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_DELETE     = 3'd2,
      CMD_FIND       = 3'd3,
      CMD_CLEAR      = 3'd4,
      CMD_MINMAX     = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

### rtl/ordered_list_engine.sv
// Each item passes through S_IDLE, S_WALK and S_FINISH; the walk covers up to CAPACITY
// entries, and a find stops at the first entry that matches its key.
// One item at a time; the walk reads one store entry per cycle through the RAM port.
// A result waiting on rsp_tready holds the following item in S_FINISH until it is taken.
// Reset: synchronous, active high; clears count, sequencer and result valid.
// Store contents are undefined after reset and are not cleared.
`default_nettype none
module ordered_list_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // key_value[31:0], position[36:32], zero pad
   input  wire logic [ole_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[2:0]
   input  wire logic [ole_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // status[1:0], found_position[6:2], min_key[38:7], max_key[70:39],
   // entry_count[75:71], zero pad
   output logic      [ole_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import ole_pkg::*;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   status_type               status_ff, status_in;
   logic [CNT_W-1:0]         found_ff, found_in;
   logic signed [KEY_W-1:0]  lo_ff, lo_in;
   logic signed [KEY_W-1:0]  hi_ff, hi_in;
   logic                     first_ff, first_in;
   logic [IDX_W-1:0]         rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]         rd_left_ff, rd_left_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_addr_ff, pend_addr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [KEY_W-1:0]         wr_data;
   logic [KEY_W-1:0]         rd_data;

   cmd_type                  req_cmd;
   logic [POS_W-1:0]         req_pos;
   logic [CMP_W-1:0]         pos_w;
   logic [CMP_W-1:0]         count_w;
   logic [CMP_W-1:0]         left_w;
   logic [CNT_W-1:0]         count_m1;
   logic                     full;
   logic [CNT_W-1:0]         next_count;

   ole_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign req_cmd  = cmd_type'(req_tuser);
   assign req_pos  = req_tdata[KEY_W +: POS_W];
   assign pos_w    = CMP_W'(req_pos);
   assign count_w  = CMP_W'(count_ff);
   assign left_w   = count_w - pos_w;
   assign count_m1 = count_ff - CNT_W'(1);
   assign full     = (count_ff == CNT_W'(CAPACITY));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_in     = first_ff;
      rd_addr_in   = rd_addr_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = 1'b0;
      pend_addr_in = rd_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff + IDX_W'(1);
      wr_data      = rd_data;
      req_tready   = 1'b0;
      next_count   = count_ff;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in     = req_cmd;
               key_in     = req_tdata[KEY_W-1:0];
               status_in  = ST_OK;
               found_in   = '0;
               lo_in      = '0;
               hi_in      = '0;
               first_in   = 1'b1;
               rd_addr_in = '0;
               rd_left_in = '0;
               state_in   = S_WALK;
               case (req_cmd)
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        rd_addr_in = count_m1[IDX_W-1:0];
                        rd_left_in = count_ff;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (pos_w == '0 || pos_w > count_w) begin
                        status_in = ST_MISS;
                     end else begin
                        rd_addr_in = pos_w[IDX_W-1:0];
                        rd_left_in = left_w[CNT_W-1:0];
                     end
                  end
                  CMD_FIND: begin
                     status_in  = ST_MISS;
                     rd_left_in = count_ff;
                  end
                  CMD_MINMAX: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_left_in = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_WALK: begin
            if (rd_left_ff != '0) begin
               pend_in      = 1'b1;
               pend_addr_in = rd_addr_ff;
               rd_left_in   = rd_left_ff - CNT_W'(1);
               if (cmd_ff == CMD_PUSH_FRONT) begin
                  rd_addr_in = rd_addr_ff - IDX_W'(1);
               end else begin
                  rd_addr_in = rd_addr_ff + IDX_W'(1);
               end
            end
            if (rd_left_ff == '0 && !pend_ff) begin
               state_in = S_FINISH;
            end
            if (pend_ff) begin
               case (cmd_ff)
                  CMD_PUSH_FRONT: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_addr_ff + IDX_W'(1);
                  end
                  CMD_DELETE: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_addr_ff - IDX_W'(1);
                  end
                  CMD_FIND: begin
                     if (rd_data == key_ff) begin
                        status_in  = ST_OK;
                        found_in   = CNT_W'(pend_addr_ff) + CNT_W'(1);
                        rd_left_in = '0;
                        pend_in    = 1'b0;
                        state_in   = S_FINISH;
                     end
                  end
                  CMD_MINMAX: begin
                     first_in = 1'b0;
                     if (first_ff || $signed(rd_data) < lo_ff) begin
                        lo_in = $signed(rd_data);
                     end
                     if (first_ff || $signed(rd_data) > hi_ff) begin
                        hi_in = $signed(rd_data);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               case (cmd_ff)
                  CMD_PUSH_FRONT: begin
                     if (status_ff == ST_OK) begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = key_ff;
                        next_count = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (status_ff == ST_OK) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_ff[IDX_W-1:0];
                        wr_data    = key_ff;
                        next_count = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DELETE: begin
                     if (status_ff == ST_OK) begin
                        next_count = count_m1;
                     end
                  end
                  CMD_CLEAR: begin
                     next_count = '0;
                  end
                  default: begin
                  end
               endcase
               count_in     = next_count;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({ECNT_W'(next_count), hi_ff, lo_ff,
                                           FPOS_W'(found_ff), status_ff});
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rd_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rd_left_ff   <= rd_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      first_ff     <= first_in;
      rd_addr_ff   <= rd_addr_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
`default_nettype wire

### rtl/ole_ram.sv
`default_nettype none
module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/ole_checker.sv
`default_nettype none
module ole_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [ole_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import ole_pkg::*;

   logic [STAT_W-1:0] rsp_status;
   logic [FPOS_W-1:0] rsp_found;
   logic [KEY_W-1:0]  rsp_min;
   logic [KEY_W-1:0]  rsp_max;
   logic [ECNT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[RSP_STAT_LO +: STAT_W];
   assign rsp_found  = rsp_tdata[RSP_FPOS_LO +: FPOS_W];
   assign rsp_min    = rsp_tdata[RSP_MIN_LO +: KEY_W];
   assign rsp_max    = rsp_tdata[RSP_MAX_LO +: KEY_W];
   assign rsp_count  = rsp_tdata[RSP_ECNT_LO +: ECNT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous one still at work");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_FULL |-> rsp_count == ECNT_W'(CAPACITY))
      else $error("store full reported with spare room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 31) || (rsp_count <= ECNT_W'(CAPACITY)))
      else $error("entry count beyond capacity");

   a_minmax_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_min) <= $signed(rsp_max)
                     && (rsp_status == ST_OK || rsp_found == '0))
      else $error("min above max or position on failed command");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);
`default_nettype wire
